// ===== rtl/vmt_pkg.sv =====
// Package for the vector move-toward-target pipeline.
// Holds the field widths and the internal datapath widths; no dependencies.
`default_nettype none
package vmt_pkg;
  localparam int AXES = 3;   // x, y, z
  localparam int CW   = 32;  // coordinate width
  localparam int BW   = 31;  // step budget width, also the quotient width
  localparam int DW   = 33;  // absolute distance on one axis
  localparam int LW   = 35;  // L1 distance over three axes
  localparam int PW   = 35;  // wrapped position and axis error, signed
  localparam int NW   = BW + DW;  // budget times distance
  localparam logic signed [PW-1:0] SAT_MAX = PW'(64'sd2147483647);
  localparam logic signed [PW-1:0] SAT_MIN = -PW'(64'sd2147483648);
endpackage
`default_nettype wire

// ===== rtl/vector_move_toward_target.sv =====
// Top level of the vector move-toward-target pipeline.
// Depends on vmt_pkg for widths and saturation limits.
//
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  input   | in_valid/in_ready, now_*, target_*,          | in
//          | step_budget, angle_mode                      |
//  output  | out_valid/out_ready, next_x, next_y, next_z  | out
//
// One vector enters per cycle unless a held result stalls the pipeline.
// The stages are input, distance/wrap and multiply, then the restoring divider,
// one quotient bit per stage over 31 stages, then the output register.
// Reset clears only the valid bits. When the output register holds a result
// that is not taken, every stage holds, so nothing is lost or repeated.
`default_nettype none
module vector_move_toward_target #(
  parameter int PI_FIXED = 205887
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  signed [vmt_pkg::CW-1:0]    now_x,
  input  wire  signed [vmt_pkg::CW-1:0]    now_y,
  input  wire  signed [vmt_pkg::CW-1:0]    now_z,
  input  wire  signed [vmt_pkg::CW-1:0]    target_x,
  input  wire  signed [vmt_pkg::CW-1:0]    target_y,
  input  wire  signed [vmt_pkg::CW-1:0]    target_z,
  input  wire         [vmt_pkg::BW-1:0]    step_budget,
  input  wire                              angle_mode,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic signed [vmt_pkg::CW-1:0]    next_x,
  output logic signed [vmt_pkg::CW-1:0]    next_y,
  output logic signed [vmt_pkg::CW-1:0]    next_z
);
  localparam int AX = vmt_pkg::AXES;
  localparam int CW = vmt_pkg::CW;
  localparam int BW = vmt_pkg::BW;
  localparam int DW = vmt_pkg::DW;
  localparam int LW = vmt_pkg::LW;
  localparam int PW = vmt_pkg::PW;
  localparam int NW = vmt_pkg::NW;
  localparam int DIVN = BW;
  localparam logic signed [PW-1:0] PI_W  = PW'(PI_FIXED);
  localparam logic signed [PW-1:0] TPI_W = PW'(2 * PI_FIXED);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage A: input register.
  logic                 a_valid;
  logic signed [CW-1:0] a_now [AX];
  logic signed [CW-1:0] a_tgt [AX];
  logic [BW-1:0]        a_budget;
  logic                 a_angle;

  // Stage B: distances, L1 sum, angle wrap.
  logic                 b_valid;
  logic [DW-1:0]        b_dist [AX];
  logic [LW-1:0]        b_total;
  logic [BW-1:0]        b_budget;
  logic signed [PW-1:0] b_pos [AX];
  logic signed [PW-1:0] b_err [AX];
  logic signed [CW-1:0] b_tgt [AX];

  // Stage C: products.
  logic                 c_valid;
  logic [NW-1:0]        c_prod [AX];
  logic [LW-1:0]        c_total;
  logic signed [PW-1:0] c_pos [AX];
  logic signed [PW-1:0] c_err [AX];
  logic signed [CW-1:0] c_tgt [AX];

  // Divider stages; stage 0 is loaded from C, stage DIVN holds the quotients.
  logic                 d_valid [DIVN+1];
  logic [LW-1:0]        d_rem   [DIVN+1][AX];
  logic [BW-1:0]        d_sh    [DIVN+1][AX];
  logic [LW-1:0]        d_total [DIVN+1];
  logic                 d_zero  [DIVN+1];
  logic signed [PW-1:0] d_pos   [DIVN+1][AX];
  logic signed [PW-1:0] d_err   [DIVN+1][AX];
  logic signed [CW-1:0] d_tgt   [DIVN+1][AX];

  // Combinational wrap and distance for stage B.
  logic signed [CW-1:0] in_now [AX];
  logic signed [CW-1:0] in_tgt [AX];
  logic signed [PW-1:0] w_d    [AX];
  logic [DW-1:0]        w_dist [AX];
  logic signed [PW-1:0] w_e0   [AX];
  logic signed [PW-1:0] w_pos  [AX];
  logic signed [PW-1:0] w_err  [AX];

  assign in_now[0] = now_x;    assign in_now[1] = now_y;    assign in_now[2] = now_z;
  assign in_tgt[0] = target_x; assign in_tgt[1] = target_y; assign in_tgt[2] = target_z;

  always_comb begin
    for (int a = 0; a < AX; a++) begin
      w_d[a]    = PW'(a_now[a]) - PW'(a_tgt[a]);
      w_dist[a] = w_d[a][PW-1] ? DW'(-w_d[a]) : DW'(w_d[a]);
      w_e0[a]   = PW'(a_tgt[a]) - PW'(a_now[a]);
      w_pos[a]  = PW'(a_now[a]);
      if (a_angle && (w_e0[a] > PI_W || w_e0[a] < -PI_W)) begin
        w_pos[a] = a_now[a][CW-1] ? PW'(a_now[a]) + TPI_W : PW'(a_now[a]) - TPI_W;
      end
      w_err[a] = PW'(a_tgt[a]) - w_pos[a];
    end
  end

  // One restoring step per divider stage.
  logic [LW:0]   s_t   [DIVN][AX];
  logic          s_ge  [DIVN][AX];
  always_comb begin
    for (int k = 0; k < DIVN; k++) begin
      for (int a = 0; a < AX; a++) begin
        s_t[k][a]  = {d_rem[k][a], d_sh[k][a][BW-1]};
        s_ge[k][a] = s_t[k][a] >= {1'b0, d_total[k]};
      end
    end
  end

  // Final move and saturation.
  logic signed [PW-1:0] m_share [AX];
  logic signed [PW-1:0] m_res   [AX];
  logic signed [CW-1:0] m_out   [AX];
  always_comb begin
    for (int a = 0; a < AX; a++) begin
      m_share[a] = PW'(d_sh[DIVN][a]);
      if (d_err[DIVN][a] <= m_share[a] && d_err[DIVN][a] >= -m_share[a]) begin
        m_res[a] = PW'(d_tgt[DIVN][a]);
      end else if (d_err[DIVN][a] > m_share[a]) begin
        m_res[a] = d_pos[DIVN][a] + m_share[a];
      end else begin
        m_res[a] = d_pos[DIVN][a] - m_share[a];
      end
      if (d_zero[DIVN]) begin
        m_out[a] = d_tgt[DIVN][a];
      end else if (m_res[a] > vmt_pkg::SAT_MAX) begin
        m_out[a] = CW'(vmt_pkg::SAT_MAX);
      end else if (m_res[a] < vmt_pkg::SAT_MIN) begin
        m_out[a] = CW'(vmt_pkg::SAT_MIN);
      end else begin
        m_out[a] = CW'(m_res[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      for (int k = 0; k <= DIVN; k++) begin
        d_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
      for (int a = 0; a < AX; a++) begin
        a_now[a] <= in_now[a];
        a_tgt[a] <= in_tgt[a];
      end
      a_budget <= step_budget;
      a_angle  <= angle_mode;

      b_valid  <= a_valid;
      b_budget <= a_budget;
      b_total  <= LW'(w_dist[0]) + LW'(w_dist[1]) + LW'(w_dist[2]);
      for (int a = 0; a < AX; a++) begin
        b_dist[a] <= w_dist[a];
        b_pos[a]  <= w_pos[a];
        b_err[a]  <= w_err[a];
        b_tgt[a]  <= a_tgt[a];
      end

      c_valid <= b_valid;
      c_total <= b_total;
      for (int a = 0; a < AX; a++) begin
        c_prod[a] <= NW'(b_budget) * NW'(b_dist[a]);
        c_pos[a]  <= b_pos[a];
        c_err[a]  <= b_err[a];
        c_tgt[a]  <= b_tgt[a];
      end

      // The quotient fits in BW bits, so the top product bits start below L.
      d_valid[0] <= c_valid;
      d_total[0] <= c_total;
      d_zero[0]  <= c_total == '0;
      for (int a = 0; a < AX; a++) begin
        d_rem[0][a] <= LW'(c_prod[a][NW-1:BW]);
        d_sh[0][a]  <= c_prod[a][BW-1:0];
        d_pos[0][a] <= c_pos[a];
        d_err[0][a] <= c_err[a];
        d_tgt[0][a] <= c_tgt[a];
      end

      for (int k = 0; k < DIVN; k++) begin
        d_valid[k+1] <= d_valid[k];
        d_total[k+1] <= d_total[k];
        d_zero[k+1]  <= d_zero[k];
        for (int a = 0; a < AX; a++) begin
          d_rem[k+1][a] <= s_ge[k][a] ? LW'(s_t[k][a] - {1'b0, d_total[k]})
                                      : LW'(s_t[k][a]);
          d_sh[k+1][a]  <= {d_sh[k][a][BW-2:0], s_ge[k][a]};
          d_pos[k+1][a] <= d_pos[k][a];
          d_err[k+1][a] <= d_err[k][a];
          d_tgt[k+1][a] <= d_tgt[k][a];
        end
      end

      out_valid <= d_valid[DIVN];
      next_x    <= m_out[0];
      next_y    <= m_out[1];
      next_z    <= m_out[2];
    end
  end

  // The L1 sum never falls below one axis distance.
  a_total_covers: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (LW'(b_dist[0]) <= b_total && LW'(b_dist[1]) <= b_total
                 && LW'(b_dist[2]) <= b_total))
    else $error("L1 sum below an axis distance");

  // Each remainder that leaves the divider stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (d_valid[DIVN] && !d_zero[DIVN]) |->
      (d_rem[DIVN][0] < d_total[DIVN] && d_rem[DIVN][1] < d_total[DIVN]
       && d_rem[DIVN][2] < d_total[DIVN]))
    else $error("divider remainder out of range");

  // A held result must not be replaced while the stages are frozen.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(next_x)
                                   && $stable(next_y) && $stable(next_z)))
    else $error("result changed during stall");
endmodule
`default_nettype wire

// ===== tb/vmt_checker.sv =====
// Checker for the vector move-toward-target block: watches both channels,
// predicts each next point and compares it with the block's output.
// Depends on vmt_pkg for field widths.
`timescale 1ns / 1ps
module vmt_checker #(
  parameter int PI_FIXED = 205887
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  input  wire                           in_ready,
  input  wire signed [vmt_pkg::CW-1:0]  now_x,
  input  wire signed [vmt_pkg::CW-1:0]  now_y,
  input  wire signed [vmt_pkg::CW-1:0]  now_z,
  input  wire signed [vmt_pkg::CW-1:0]  target_x,
  input  wire signed [vmt_pkg::CW-1:0]  target_y,
  input  wire signed [vmt_pkg::CW-1:0]  target_z,
  input  wire        [vmt_pkg::BW-1:0]  step_budget,
  input  wire                           angle_mode,
  input  wire                           out_valid,
  input  wire                           out_ready,
  input  wire signed [vmt_pkg::CW-1:0]  next_x,
  input  wire signed [vmt_pkg::CW-1:0]  next_y,
  input  wire signed [vmt_pkg::CW-1:0]  next_z,
  output int                            mismatches,
  output int                            pending
);
  typedef logic signed [vmt_pkg::CW-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  point_t next_points[$];

  // One axis of the step; all arithmetic is done in 64 bits.
  function automatic coord_t step_axis(longint cur, longint goal, longint share,
                                       bit wrap);
    longint err;
    longint moved;
    err = goal - cur;
    if (wrap && (err > PI_FIXED || err < -PI_FIXED)) begin
      if (cur < 0) cur = cur + 2 * longint'(PI_FIXED);
      else cur = cur - 2 * longint'(PI_FIXED);
      err = goal - cur;
    end
    if (err <= share && err >= -share) moved = goal;
    else if (err > share) moved = cur + share;
    else moved = cur - share;
    if (moved > 64'sd2147483647) moved = 64'sd2147483647;
    if (moved < -64'sd2147483648) moved = -64'sd2147483648;
    return coord_t'(moved);
  endfunction

  function automatic point_t predict_next(point_t cur, point_t goal,
                                          logic [vmt_pkg::BW-1:0] budget, bit wrap);
    longint c[3];
    longint g[3];
    longint d[3];
    longint l1;
    longint unsigned prod;
    coord_t r[3];
    c[0] = cur.x; c[1] = cur.y; c[2] = cur.z;
    g[0] = goal.x; g[1] = goal.y; g[2] = goal.z;
    l1 = 0;
    for (int a = 0; a < 3; a++) begin
      d[a] = c[a] - g[a];
      if (d[a] < 0) d[a] = -d[a];
      l1 += d[a];
    end
    for (int a = 0; a < 3; a++) begin
      if (l1 == 0) begin
        r[a] = coord_t'(g[a]);
      end else begin
        // Budget below 2^31 times distance below 2^33 fits in 64 unsigned bits.
        prod = longint'(budget) * d[a];
        r[a] = step_axis(c[a], g[a], longint'(prod / longint'(l1)), wrap);
      end
    end
    return '{r[0], r[1], r[2]};
  endfunction

  assign pending = next_points.size();

  always @(posedge clk) begin
    point_t exp_pt;
    if (rst) begin
      mismatches <= 0;
    end else begin
      if (in_valid && in_ready)
        next_points.push_back(predict_next('{now_x, now_y, now_z},
          '{target_x, target_y, target_z}, step_budget, angle_mode));
      if (out_valid && out_ready) begin
        if (next_points.size() == 0) begin
          if (mismatches < 10) $display("Unexpected output %0d %0d %0d",
                                        next_x, next_y, next_z);
          mismatches <= mismatches + 1;
        end else begin
          exp_pt = next_points.pop_front();
          if (exp_pt != {next_x, next_y, next_z}) begin
            if (mismatches < 10)
              $display("Point mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       exp_pt.x, exp_pt.y, exp_pt.z, next_x, next_y, next_z);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/tb_vector_move_toward_target.sv =====
// Testbench top for vector_move_toward_target: drives directed and random
// vectors with random gaps and stalls. Depends on vmt_pkg and vmt_checker.
`timescale 1ns / 1ps
module tb_vector_move_toward_target;
  localparam int PI = 205887;
  localparam int N_RANDOM = 880;
  localparam int LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] now_x, now_y, now_z, target_x, target_y, target_z;
  logic [30:0] step_budget;
  logic angle_mode;
  logic out_valid;
  logic out_ready;
  logic signed [31:0] next_x, next_y, next_z;
  int mismatches;
  int pending;
  int cycles;

  vector_move_toward_target #(.PI_FIXED(PI)) uut (.*);
  vmt_checker #(.PI_FIXED(PI)) chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1;
    in_valid = 0;
    out_ready = 0;
    {now_x, now_y, now_z, target_x, target_y, target_z} = '0;
    step_budget = '0;
    angle_mode = 0;
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 2 * PI) - PI;
      3: return $urandom_range(0, 8 * PI) - 4 * PI;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_budget();
    case ($urandom_range(0, 3))
      0: return 31'h7fffffff;
      1: return 31'($urandom_range(0, 4 * PI));
      default: return 31'($urandom);
    endcase
  endfunction

  // Valid drops only across a gap, so back-to-back transfers keep it high.
  task automatic send_vector(logic [31:0] nx, ny, nz, tx, ty, tz,
                             logic [30:0] bud, logic am);
    int gap;
    gap = $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {now_x, now_y, now_z} <= {nx, ny, nz};
    {target_x, target_y, target_z} <= {tx, ty, tz};
    step_budget <= bud;
    angle_mode <= am;
    do @(posedge clk); while (!in_ready);
  endtask

  // Receiver: random stalls, with one long hold-off so the pipeline fills.
  initial begin
    int wait_cycles;
    @(negedge rst);
    repeat (200) @(posedge clk);
    out_ready <= 0;
    repeat (120) @(posedge clk);
    forever begin
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (wait_cycles > 0) begin
        out_ready <= 0;
        repeat (wait_cycles) @(posedge clk);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] c;
    repeat (7) @(posedge clk);
    rst <= 0;
    // Directed: at target, extremes, zero budget, wrap both ways.
    send_vector(5, -7, 9, 5, -7, 9, 31'h7fffffff, 1'b0);
    send_vector(32'h80000000, 32'h80000000, 32'h80000000,
                32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff, 1'b0);
    send_vector(32'h7fffffff, 0, 32'h80000000,
                32'h80000000, 0, 32'h7fffffff, 31'h7fffffff, 1'b1);
    send_vector(100, 200, 300, 1000, -2000, 3000, 31'd0, 1'b0);
    send_vector(100, 200, 300, 1000, -2000, 3000, 31'h7fffffff, 1'b0);
    send_vector(0, 0, 0, 1, 0, 0, 31'd1, 1'b0);
    send_vector(-PI, PI, 0, PI, -PI, PI, 31'd1000, 1'b1);
    send_vector(-10, 10, 0, PI, -PI, PI + 1, 31'd5000, 1'b1);
    send_vector(3 * PI, -3 * PI, 0, -3 * PI, 3 * PI, 0, 31'h7fffffff, 1'b1);
    send_vector(32'h7fffffff, 32'h80000000, 5, -PI, PI, 5, 31'h7fffffff, 1'b1);
    send_vector(10, 20, 30, 10, 25, 30, 31'd3, 1'b0);
    send_vector(-1, -1, -1, 1, 1, 1, 31'd2, 1'b1);
    for (int i = 0; i < N_RANDOM; i++) begin
      c = pick_coord();
      if ($urandom_range(0, 9) == 0)
        send_vector(c, c + 1, c - 1, c, c + 1, c - 1, pick_budget(), 1'($urandom));
      else
        send_vector(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_budget(), 1'($urandom));
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/vmt_pkg.sv
rtl/vector_move_toward_target.sv
tb/vmt_checker.sv
tb/tb_vector_move_toward_target.sv
